// ===== rtl/core/srma_pkg.sv =====
// Shared widths, the reset jump limit and the flag type of the spike-rejecting moving-average filter.
package srma_pkg;

  localparam int unsigned TEMP_W  = 12;
  localparam int unsigned HUMI_W  = 10;
  localparam int unsigned LIMIT_W = 11;
  localparam int unsigned TDATA_W = 24;
  localparam int unsigned TUSER_W = 4;

  localparam logic [LIMIT_W-1:0] JUMP_LIMIT_RESET = 11'd20;

  typedef struct packed {
    logic replaced;
    logic updated;
  } chan_flags_t;

endpackage

// ===== rtl/core/spike_reject_moving_average.sv =====
// Top level of the spike-rejecting moving-average filter for temperature and humidity.
//
//  Channel   Direction  Handshake                        Payload
//  cfg       in         cfg_we_i                         cfg_wdata_i = jump_limit
//  s_axis    in         s_axis_tvalid_i/s_axis_tready_o  tdata = temp, humi readings
//  m_axis    out        m_axis_tvalid_o/m_axis_tready_i  tdata = values, tuser = flags
//
// Each accepted item has its registered result in the cycle after; one item per cycle while results are taken.
// The window average is precomputed from a running sum and registered, so the jump
// check, window update and next average fit between the input port and the result register.
// Reset leaves the filter unseeded with jump_limit at 20; the next item seeds the window.
// While the result register is full and not taken, s_axis_tready_o stays low.
module spike_reject_moving_average #(
  parameter int unsigned WINDOW_LEN = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [srma_pkg::LIMIT_W-1:0]  cfg_wdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [11:0] temp_reading, [21:12] humi_reading, [23:22] zero
  input  logic [srma_pkg::TDATA_W-1:0]  s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [11:0] temp_value, [21:12] humi_value, [23:22] zero
  output logic [srma_pkg::TDATA_W-1:0]  m_axis_tdata_o,
  // [0] temp_updated, [1] humi_updated, [2] temp_replaced, [3] humi_replaced
  output logic [srma_pkg::TUSER_W-1:0]  m_axis_tuser_o
);

  localparam int unsigned TW  = srma_pkg::TEMP_W;
  localparam int unsigned HW  = srma_pkg::HUMI_W;
  // Humidity runs through the signed channel with one extra zero sign bit.
  localparam int unsigned HSW = HW + 1;
  localparam int unsigned PAD = srma_pkg::TDATA_W - TW - HW;

  logic                         in_acc;
  logic                         out_valid_q;
  logic                         seeded_q;
  logic [srma_pkg::LIMIT_W-1:0] limit_q;
  logic signed [TW-1:0]         temp_in;
  logic signed [HSW-1:0]        humi_in;
  logic signed [TW-1:0]         temp_val;
  logic signed [HSW-1:0]        humi_val;
  srma_pkg::chan_flags_t        temp_flags;
  srma_pkg::chan_flags_t        humi_flags;
  logic [TW-1:0]                out_temp_q;
  logic [HW-1:0]                out_humi_q;
  srma_pkg::chan_flags_t        out_temp_flags_q;
  srma_pkg::chan_flags_t        out_humi_flags_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign temp_in = signed'(s_axis_tdata_i[TW-1:0]);
  assign humi_in = signed'({1'b0, s_axis_tdata_i[TW+HW-1:TW]});

  srma_channel #(
    .DW         (TW),
    .WINDOW_LEN (WINDOW_LEN)
  ) u_temp (
    .clk_i     (clk_i),
    .en_i      (in_acc),
    .seed_i    (!seeded_q),
    .reading_i (temp_in),
    .limit_i   (limit_q),
    .value_o   (temp_val),
    .flags_o   (temp_flags)
  );

  srma_channel #(
    .DW         (HSW),
    .WINDOW_LEN (WINDOW_LEN)
  ) u_humi (
    .clk_i     (clk_i),
    .en_i      (in_acc),
    .seed_i    (!seeded_q),
    .reading_i (humi_in),
    .limit_i   (limit_q),
    .value_o   (humi_val),
    .flags_o   (humi_flags)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      seeded_q    <= 1'b0;
      limit_q     <= srma_pkg::JUMP_LIMIT_RESET;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        seeded_q    <= 1'b1;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_temp_q       <= temp_val;
      out_humi_q       <= humi_val[HW-1:0];
      out_temp_flags_q <= temp_flags;
      out_humi_flags_q <= humi_flags;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {PAD'(0), out_humi_q, out_temp_q};
  assign m_axis_tuser_o  = {out_humi_flags_q.replaced, out_temp_flags_q.replaced,
                            out_humi_flags_q.updated, out_temp_flags_q.updated};

endmodule

// ===== rtl/core/srma_avg_div.sv =====
// Truncating signed division of a window sum by the window length, by reciprocal multiply.
module srma_avg_div #(
  parameter int unsigned DW         = 12,
  parameter int unsigned SW         = 15,
  parameter int unsigned WINDOW_LEN = 8
) (
  input  logic signed [SW-1:0] sum_i,
  output logic signed [DW-1:0] avg_o
);

  localparam int unsigned LOG_N     = $clog2(WINDOW_LEN);
  localparam int unsigned DIV_SHIFT = SW + LOG_N;
  // With the magnitude below 2**SW and the divisor at most 2**LOG_N, the rounded-up
  // reciprocal scaled by 2**(SW+LOG_N) gives the exact floor quotient.
  localparam longint unsigned MUL_CONST =
    ((64'd1 << DIV_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;

  logic [SW-1:0]   mag;
  logic [SW:0]     recip;
  logic [2*SW:0]   prod;
  logic [DW-1:0]   quo;

  assign recip = (SW+1)'(MUL_CONST);

  always_comb begin
    mag   = sum_i[SW-1] ? SW'(-sum_i) : SW'(sum_i);
    prod  = (2*SW+1)'(mag) * (2*SW+1)'(recip);
    quo   = DW'(prod >> DIV_SHIFT);
    avg_o = sum_i[SW-1] ? -signed'(quo) : signed'(quo);
  end

endmodule

// ===== rtl/core/srma_channel.sv =====
// One filter channel: last value, window shift line, running sum, average and jump check.
module srma_channel #(
  parameter int unsigned DW         = 12,
  parameter int unsigned WINDOW_LEN = 8
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic                            seed_i,
  input  logic signed [DW-1:0]            reading_i,
  input  logic [srma_pkg::LIMIT_W-1:0]    limit_i,
  output logic signed [DW-1:0]            value_o,
  output srma_pkg::chan_flags_t           flags_o
);

  localparam int unsigned LOG_N = $clog2(WINDOW_LEN);
  localparam int unsigned SW    = DW + LOG_N;

  // The window slot that is written next always holds the entry written WINDOW_LEN
  // items ago, so the circular window is kept as a shift line read at its tail.
  logic signed [DW-1:0] taps_q [WINDOW_LEN];
  logic signed [DW-1:0] last_q;
  logic signed [DW-1:0] avg_q;
  logic signed [DW-1:0] avg_d;
  logic signed [DW-1:0] tail;
  logic signed [DW-1:0] accepted;
  logic signed [DW-1:0] entry;
  logic signed [SW-1:0] sum_q;
  logic signed [SW-1:0] sum_d;
  logic signed [SW-1:0] seed_sum;
  logic signed [DW:0]   diff;
  logic [DW:0]          diff_mag;
  logic                 changed;
  logic                 over;

  assign tail = taps_q[WINDOW_LEN-1];

  always_comb begin
    diff     = (DW+1)'(reading_i) - (DW+1)'(last_q);
    diff_mag = diff[DW] ? (DW+1)'(-diff) : (DW+1)'(diff);
    changed  = (reading_i != last_q);
    over     = (diff_mag > (DW+1)'(limit_i));
    accepted = over ? avg_q : reading_i;
    entry    = changed ? accepted : tail;
    sum_d    = sum_q - SW'(tail) + SW'(entry);
    seed_sum = SW'(SW'(reading_i) * WINDOW_LEN);

    if (seed_i) begin
      value_o = reading_i;
    end else if (changed) begin
      value_o = accepted;
    end else begin
      value_o = last_q;
    end
    flags_o.updated  = seed_i | changed;
    flags_o.replaced = !seed_i & changed & over;
  end

  srma_avg_div #(
    .DW         (DW),
    .SW         (SW),
    .WINDOW_LEN (WINDOW_LEN)
  ) u_avg_div (
    .sum_i (sum_d),
    .avg_o (avg_d)
  );

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (seed_i) begin
        last_q <= reading_i;
        sum_q  <= seed_sum;
        avg_q  <= reading_i;
        for (int i = 0; i < WINDOW_LEN; i++) begin
          taps_q[i] <= reading_i;
        end
      end else begin
        if (changed) begin
          last_q <= accepted;
        end
        sum_q     <= sum_d;
        avg_q     <= avg_d;
        taps_q[0] <= entry;
        for (int i = 1; i < WINDOW_LEN; i++) begin
          taps_q[i] <= taps_q[i-1];
        end
      end
    end
  end

endmodule

// ===== rtl/core/srma_checker.sv =====
// Port-level checks of the spike-rejecting moving-average filter, bound to its top level.
module srma_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_tvalid_i,
  input logic                          s_tready_i,
  input logic                          m_tvalid_i,
  input logic                          m_tready_i,
  input logic [srma_pkg::TUSER_W-1:0]  m_tuser_i
);

  // Every accepted item shows a result in the next cycle.
  a_item_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i |=> m_tvalid_i)
    else $error("accepted item did not produce a result");

  // The input side only stalls behind a result that is waiting.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_i |-> m_tvalid_i && !m_tready_i)
    else $error("input stalled without a waiting result");

  // A replaced value is always a stored value.
  a_replaced_implies_updated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> (!m_tuser_i[2] || m_tuser_i[0]) && (!m_tuser_i[3] || m_tuser_i[1]))
    else $error("replaced flag without updated flag");

  // A stalled result stays valid and its flags hold.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tuser_i))
    else $error("stalled result changed");

endmodule

bind spike_reject_moving_average srma_checker u_srma_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tuser_i  (m_axis_tuser_o)
);

// ===== tb/sv/spike_reject_moving_average_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the spike-rejecting moving-average filter.
module spike_reject_moving_average_test;

  localparam int WIN         = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TEMP_MIN    = -2048;
  localparam int TEMP_MAX    = 2047;
  localparam int HUMI_MIN    = 0;
  localparam int HUMI_MAX    = 1023;
  localparam int LIMIT_MAX   = 2047;
  localparam int PHASE_ITEMS = 155;

  // Tracks the filter state and holds the filtered values still owed by the block.
  class filter_tracker;
    typedef struct {
      logic [srma_pkg::TEMP_W-1:0] temp_value;
      logic [srma_pkg::HUMI_W-1:0] humi_value;
      logic [3:0]                  flags;
    } filtered_t;

    filtered_t expected_filtered[$];
    int errors;
    int readings;
    int results;
    int replacements;
    int unchanged;
    bit seeded;
    int limit;
    int last_val[2];
    int window[2][WIN];
    int pos;

    function new();
      limit = int'(srma_pkg::JUMP_LIMIT_RESET);
      seeded = 1'b0;
      pos = 0;
      for (int c = 0; c < 2; c++) begin
        last_val[c] = 0;
        for (int k = 0; k < WIN; k++) window[c][k] = 0;
      end
    endfunction

    // Returns bit 0 set when the value was stored, bit 1 when the average replaced it.
    function int filter_channel(int ch, int reading);
      int sum;
      int avg;
      int v;
      int f;
      sum = 0;
      for (int k = 0; k < WIN; k++) sum += window[ch][k];
      // Signed int division truncates toward zero.
      avg = sum / WIN;
      f = 0;
      if (reading != last_val[ch]) begin
        v = reading;
        f = 1;
        if (reading > last_val[ch] + limit || reading < last_val[ch] - limit) begin
          v = avg;
          f = 3;
        end
        last_val[ch] = v;
        window[ch][pos] = v;
      end
      return f;
    endfunction

    function void note_reading(logic [srma_pkg::TDATA_W-1:0] d);
      int t;
      int h;
      int tf;
      int hf;
      filtered_t e;
      t = int'($signed(d[11:0]));
      h = int'(d[21:12]);
      readings++;
      if (!seeded) begin
        // The first item fills the whole window and leaves the position alone.
        seeded = 1'b1;
        last_val[0] = t;
        last_val[1] = h;
        for (int k = 0; k < WIN; k++) begin
          window[0][k] = t;
          window[1][k] = h;
        end
        tf = 1;
        hf = 1;
      end else begin
        tf = filter_channel(0, t);
        hf = filter_channel(1, h);
        pos = (pos + 1) % WIN;
      end
      unchanged += (tf == 0) + (hf == 0);
      replacements += tf[1] + hf[1];
      e.temp_value = last_val[0][11:0];
      e.humi_value = last_val[1][9:0];
      e.flags = {hf[1], tf[1], hf[0], tf[0]};
      expected_filtered.push_back(e);
    endfunction

    task report_mismatch(string what, int got, int want);
      errors++;
      if (errors <= 40)
        $display("ERROR: result %0d, %s: got %0d, expected %0d", results, what, got, want);
    endtask

    task check_result(logic [srma_pkg::TDATA_W-1:0] data,
                      logic [srma_pkg::TUSER_W-1:0] user);
      filtered_t e;
      string flag_name[4];
      flag_name = '{"temp_updated", "humi_updated", "temp_replaced", "humi_replaced"};
      results++;
      if (expected_filtered.size() == 0) begin
        report_mismatch("result with nothing pending, tdata", int'(data), 0);
        return;
      end
      e = expected_filtered.pop_front();
      if (data[11:0] !== e.temp_value)
        report_mismatch("temp_value", $signed(data[11:0]), $signed(e.temp_value));
      if (data[21:12] !== e.humi_value)
        report_mismatch("humi_value", int'(data[21:12]), int'(e.humi_value));
      if (data[23:22] !== 2'b00)
        report_mismatch("tdata padding", int'(data[23:22]), 0);
      for (int k = 0; k < 4; k++)
        if (user[k] !== e.flags[k])
          report_mismatch(flag_name[k], int'(user[k]), int'(e.flags[k]));
    endtask
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [srma_pkg::LIMIT_W-1:0]  cfg_wdata = '0;
  logic                          s_valid = 1'b0;
  logic [srma_pkg::TDATA_W-1:0]  s_data = '0;
  logic                          s_ready;
  logic                          m_valid;
  logic                          m_ready = 1'b0;
  logic [srma_pkg::TDATA_W-1:0]  m_data;
  logic [srma_pkg::TUSER_W-1:0]  m_user;

  filter_tracker tracker = new();
  int send_gap_pct = 0;
  int stall_pct = 0;
  int cycles = 0;

  spike_reject_moving_average #(
    .WINDOW_LEN(WIN)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending.", cycles,
               tracker.expected_filtered.size());
      $display("spike_reject_moving_average: mismatch");
      $finish;
    end
  end

  // Result side: check what was taken at this edge, then choose the next ready.
  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) tracker.check_result(m_data, m_user);
    m_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic int clip(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Mostly small steps around the last value, with repeats, steps at or just past
  // the limit and now and then a reading from anywhere in the range.
  function automatic int next_value(int prev, int lo, int hi, int lim);
    int pick;
    int span;
    int delta;
    pick = $urandom_range(99);
    span = lim + lim / 4 + 2;
    if (pick < 15) return prev;
    if (pick < 25) return lo + int'($urandom_range(hi - lo));
    if (pick < 40) begin
      delta = lim + int'($urandom_range(1));
      if ($urandom_range(1) == 1) delta = -delta;
    end else begin
      delta = int'($urandom_range(2 * span)) - span;
    end
    return clip(prev + delta, lo, hi);
  endfunction

  task send_reading(int t, int h);
    logic [srma_pkg::TDATA_W-1:0] d;
    int gap;
    d = {2'b00, h[9:0], t[11:0]};
    s_valid <= 1'b1;
    s_data <= d;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    tracker.note_reading(d);
    gap = 0;
    while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) gap++;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task send_step(int dt, int dh);
    send_reading(clip(tracker.last_val[0] + dt, TEMP_MIN, TEMP_MAX),
                 clip(tracker.last_val[1] + dh, HUMI_MIN, HUMI_MAX));
  endtask

  // Always lets at least one edge pass so the next item starts in a later step.
  task drain();
    s_valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_filtered.size() != 0) @(posedge clk);
  endtask

  // The block holds no item beyond its result register, so an empty queue means it is idle.
  task write_limit(int v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v[10:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.limit = v;
  endtask

  initial begin
    int lim;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, starting with the limit left by reset.
    send_reading(100, 500);
    send_step(0, 0);
    send_step(20, -20);
    send_step(-20, 20);
    send_step(21, -21);
    send_step(-21, 21);
    send_step(0, 3);
    send_step(-5, 0);
    send_reading(TEMP_MIN, HUMI_MIN);
    send_reading(TEMP_MAX, HUMI_MAX);
    write_limit(LIMIT_MAX);
    send_reading(TEMP_MAX, HUMI_MAX);
    send_reading(0, 0);
    send_reading(TEMP_MIN, HUMI_MAX);
    send_reading(TEMP_MAX, HUMI_MIN);
    write_limit(0);
    send_step(1, 1);
    send_step(0, 0);
    send_step(-1, -1);
    send_reading(-1, 512);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: lim = 20;
        1: lim = 0;
        2: lim = LIMIT_MAX;
        3: lim = $urandom_range(1, 100);
        4: lim = $urandom_range(LIMIT_MAX);
        default: lim = 1;
      endcase
      write_limit(lim);
      case (ph % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 45; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 45; end
        default: begin send_gap_pct = 27; stall_pct = 27; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Halfway through, hold off until every pending result is out.
        if (n == PHASE_ITEMS / 2) drain();
        send_reading(next_value(tracker.last_val[0], TEMP_MIN, TEMP_MAX, lim),
                     next_value(tracker.last_val[1], HUMI_MIN, HUMI_MAX, lim));
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Covered %0d readings and %0d filtered results over jump limits from 0 to %0d,",
             tracker.readings, tracker.results, LIMIT_MAX);
    $display("with %0d replaced and %0d unchanged channel readings under four idling styles.",
             tracker.replacements, tracker.unchanged);
    if (tracker.errors == 0) begin
      $display("spike_reject_moving_average: match");
    end else begin
      $display("spike_reject_moving_average: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/srma_pkg.sv
rtl/core/srma_avg_div.sv
rtl/core/srma_channel.sv
rtl/core/spike_reject_moving_average.sv
rtl/core/srma_checker.sv
tb/sv/spike_reject_moving_average_test.sv
